### src/mvng_pkg.sv
// Shared types and constants of the mesh vertex normal generator.
package mvng_pkg;

  localparam int CoordW       = 16;
  localparam int NormFracBits = 14;
  localparam int NormW        = 16;
  localparam int IdxW         = 10;
  localparam int ItemW        = 11;
  localparam int CountW       = 12;
  localparam int AccW         = 36;
  localparam int MagLimit     = 30;
  localparam int SqW          = 62;
  localparam int LenW         = 32;
  localparam int MulW         = 32;
  localparam int NumW         = MagLimit + NormFracBits + 1;
  localparam int DivCntW      = $clog2(NumW + 1);
  localparam int QDepth       = 2;
  localparam logic [NumW-1:0] NormOne = NumW'(1) << NormFracBits;

  typedef enum logic [1:0] {
    REQ_VERTEX,
    REQ_TRIANGLE,
    REQ_QUERY,
    REQ_CLEAR
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_RANGE,
    STAT_FULL,
    STAT_ZERO
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_CROSS,
    S_WALK,
    S_MAG,
    S_SHRINK,
    S_SQ,
    S_SQRT,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_DIV_STORE,
    S_EMIT
  } state_e;

  typedef struct packed {
    req_e                      req;
    logic signed [CoordW-1:0]  pos_x;
    logic signed [CoordW-1:0]  pos_y;
    logic signed [CoordW-1:0]  pos_z;
    logic [IdxW-1:0]           corner_a;
    logic [IdxW-1:0]           corner_b;
    logic [IdxW-1:0]           corner_c;
    logic [IdxW-1:0]           query_vertex;
  } cmd_t;

  typedef struct {
    logic valid;
    logic ready;
  } hs_t;

endpackage

### src/mvng_front.sv
// Input side: accepts items, decodes the request and queues commands for the back end.
module mvng_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic signed [mvng_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [mvng_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [mvng_pkg::CoordW-1:0] pos_z_i,
  input  logic [mvng_pkg::IdxW-1:0]         corner_a_i,
  input  logic [mvng_pkg::IdxW-1:0]         corner_b_i,
  input  logic [mvng_pkg::IdxW-1:0]         corner_c_i,
  input  logic [mvng_pkg::IdxW-1:0]         query_vertex_i,
  output mvng_pkg::cmd_t                    cmd_o,
  output logic                              cmd_valid_o,
  input  logic                              cmd_ready_i
);
  import mvng_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  cmd_t            q_mem [QDepth];
  cmd_t            in_cmd;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  always_comb begin
    in_cmd.req          = req_e'(req_type_i);
    in_cmd.pos_x        = pos_x_i;
    in_cmd.pos_y        = pos_y_i;
    in_cmd.pos_z        = pos_z_i;
    in_cmd.corner_a     = corner_a_i;
    in_cmd.corner_b     = corner_b_i;
    in_cmd.corner_c     = corner_c_i;
    in_cmd.query_vertex = query_vertex_i;
  end

  assign in_ready_o  = (cnt_q != (PtrW+1)'(QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

### src/mvng_back.sv
// Execution side: mesh stores, cross product, triangle walk, normalization and result register.
module mvng_back #(
  parameter int MAX_VERTICES  = 1024,
  parameter int MAX_TRIANGLES = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mvng_pkg::cmd_t                     cmd_i,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  output logic signed [mvng_pkg::NormW-1:0]  normal_x_o,
  output logic signed [mvng_pkg::NormW-1:0]  normal_y_o,
  output logic signed [mvng_pkg::NormW-1:0]  normal_z_o,
  output logic                               result_kind_o,
  output logic [mvng_pkg::ItemW-1:0]         item_index_o,
  output logic [mvng_pkg::CountW-1:0]        usage_count_o,
  output logic [1:0]                         status_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i
);
  import mvng_pkg::*;

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int TAW = $clog2(MAX_TRIANGLES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int TCW = $clog2(MAX_TRIANGLES + 1);

  logic [3*CoordW-1:0] vmem [MAX_VERTICES];
  logic [3*IdxW-1:0]   cmem [MAX_TRIANGLES];
  logic [3*NormW-1:0]  nmem [MAX_TRIANGLES];

  state_e state_q, state_d;
  cmd_t   cmd_q;

  logic [VCW-1:0] vcount_q;
  logic [TCW-1:0] tcount_q, ptr_q, ucount_q;
  logic [2:0]     sub_q;
  logic           issue_q, store_tri_q;
  logic [1:0]     comp_q;
  logic [DivCntW-1:0] dcnt_q;

  logic [3*CoordW-1:0]      vrd_q, pa_q, pb_q;
  logic [3*IdxW-1:0]        crd_q;
  logic [3*NormW-1:0]       nrd_q;
  logic signed [CoordW:0]   e1_q [3];
  logic signed [CoordW:0]   e2_q [3];
  logic signed [AccW-1:0]   acc_q [3];
  logic [AccW-1:0]          mag_q [3];
  logic                     neg_q [3];
  logic signed [2*MulW-1:0] prod_q;
  logic [SqW-1:0]           sum_q, rem_q, bit_q, root_q;
  logic [NumW-1:0]          num_q, quot_q;
  logic [LenW:0]            drem_q;

  logic signed [NormW-1:0]  res_n_q [3];
  logic                     res_kind_q;
  logic [ItemW-1:0]         res_idx_q;
  status_e                  res_status_q;

  logic                     out_valid_q;
  logic signed [NormW-1:0]  out_n_q [3];
  logic                     out_kind_q;
  logic [ItemW-1:0]         out_idx_q;
  logic [CountW-1:0]        out_count_q;
  status_e                  out_status_q;

  logic                     tri_full, range_bad, q_bad, walk_done, big, out_free, match;
  logic                     vert_ok;
  logic [VAW-1:0]           vaddr;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic [SqW-1:0]           sum_fin;
  logic [SqW:0]             sq_trial;
  logic [LenW:0]            div_sh;
  logic [NumW-1:0]          capped;

  function automatic logic signed [CoordW:0] diff_c(input logic [3*CoordW-1:0] p,
                                                    input logic [3*CoordW-1:0] q,
                                                    input int i);
    logic signed [CoordW-1:0] pc, qc;
    pc = p[(2-i)*CoordW +: CoordW];
    qc = q[(2-i)*CoordW +: CoordW];
    return (CoordW+1)'(pc) - (CoordW+1)'(qc);
  endfunction

  assign tri_full  = (32'(tcount_q) >= MAX_TRIANGLES);
  assign range_bad = (32'(cmd_i.corner_a) >= 32'(vcount_q)) ||
                     (32'(cmd_i.corner_b) >= 32'(vcount_q)) ||
                     (32'(cmd_i.corner_c) >= 32'(vcount_q));
  assign q_bad     = (32'(cmd_i.query_vertex) >= 32'(vcount_q));
  assign vert_ok   = (32'(vcount_q) < MAX_VERTICES);
  assign walk_done = (ptr_q == tcount_q) && !issue_q;
  assign big       = (|mag_q[0][AccW-1:MagLimit]) || (|mag_q[1][AccW-1:MagLimit]) ||
                     (|mag_q[2][AccW-1:MagLimit]);
  assign out_free  = !out_valid_q || out_ready_i;
  assign match     = (crd_q[3*IdxW-1:2*IdxW] == cmd_q.query_vertex) ||
                     (crd_q[2*IdxW-1:IdxW] == cmd_q.query_vertex) ||
                     (crd_q[IdxW-1:0] == cmd_q.query_vertex);
  assign sum_fin   = sum_q + prod_q[SqW-1:0];
  assign sq_trial  = {1'b0, root_q} + {1'b0, bit_q};
  assign div_sh    = {drem_q[LenW-1:0], num_q[NumW-1]};
  assign capped    = (quot_q > NormOne) ? NormOne : quot_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.req)
            REQ_TRIANGLE: state_d = (tri_full || range_bad) ? S_EMIT : S_FETCH;
            REQ_QUERY:    state_d = q_bad ? S_EMIT : S_WALK;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_FETCH:     if (sub_q == 3'd3) state_d = S_CROSS;
      S_CROSS:     if (sub_q == 3'd6) state_d = S_MAG;
      S_WALK:      if (walk_done) state_d = (ucount_q == '0) ? S_EMIT : S_MAG;
      S_MAG:       state_d = S_SHRINK;
      S_SHRINK:    if (!big) state_d = S_SQ;
      S_SQ:        if (sub_q == 3'd3) state_d = (sum_fin == '0) ? S_EMIT : S_SQRT;
      S_SQRT:      if (bit_q[0]) state_d = S_DIV_LOAD;
      S_DIV_LOAD:  state_d = S_DIV_RUN;
      S_DIV_RUN:   if (dcnt_q == DivCntW'(NumW - 1)) state_d = S_DIV_STORE;
      S_DIV_STORE: state_d = (comp_q == 2'd2) ? S_EMIT : S_DIV_LOAD;
      S_EMIT:      if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o = (state_q == S_IDLE);
    vaddr       = '0;
    mul_a       = '0;
    mul_b       = '0;
    case (state_q)
      S_FETCH: begin
        case (sub_q)
          3'd0:    vaddr = VAW'(32'(cmd_q.corner_a));
          3'd1:    vaddr = VAW'(32'(cmd_q.corner_b));
          default: vaddr = VAW'(32'(cmd_q.corner_c));
        endcase
      end
      S_CROSS: begin
        case (sub_q)
          3'd0: begin mul_a = MulW'(e1_q[1]); mul_b = MulW'(e2_q[2]); end
          3'd1: begin mul_a = MulW'(e1_q[2]); mul_b = MulW'(e2_q[1]); end
          3'd2: begin mul_a = MulW'(e1_q[2]); mul_b = MulW'(e2_q[0]); end
          3'd3: begin mul_a = MulW'(e1_q[0]); mul_b = MulW'(e2_q[2]); end
          3'd4: begin mul_a = MulW'(e1_q[0]); mul_b = MulW'(e2_q[1]); end
          3'd5: begin mul_a = MulW'(e1_q[1]); mul_b = MulW'(e2_q[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_SQ: begin
        if (sub_q < 3'd3) begin
          mul_a = $signed(MulW'(mag_q[sub_q[1:0]][MagLimit-1:0]));
          mul_b = mul_a;
        end
      end
      default: begin
        vaddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sub_q       <= '0;
      vcount_q    <= '0;
      tcount_q    <= '0;
      ptr_q       <= '0;
      issue_q     <= 1'b0;
      ucount_q    <= '0;
      store_tri_q <= 1'b0;
      comp_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sub_q   <= (state_d != state_q) ? 3'd0 : sub_q + 3'd1;
      case (state_q)
        S_IDLE: begin
          ptr_q    <= '0;
          issue_q  <= 1'b0;
          ucount_q <= '0;
          if (cmd_valid_i) begin
            store_tri_q <= (cmd_i.req == REQ_TRIANGLE) && !tri_full && !range_bad;
            if (cmd_i.req == REQ_VERTEX && vert_ok) begin
              vcount_q <= vcount_q + 1'b1;
            end
            if (cmd_i.req == REQ_CLEAR) begin
              vcount_q <= '0;
              tcount_q <= '0;
            end
          end
        end
        S_WALK: begin
          if (ptr_q != tcount_q) begin
            ptr_q   <= ptr_q + 1'b1;
            issue_q <= 1'b1;
          end else begin
            issue_q <= 1'b0;
          end
          if (issue_q && match) begin
            ucount_q <= ucount_q + 1'b1;
          end
        end
        S_MAG: comp_q <= '0;
        S_DIV_LOAD: dcnt_q <= '0;
        S_DIV_RUN: dcnt_q <= dcnt_q + 1'b1;
        S_DIV_STORE: comp_q <= comp_q + 2'd1;
        S_EMIT: begin
          if (out_free && store_tri_q) begin
            tcount_q <= tcount_q + 1'b1;
          end
        end
        default: begin
          comp_q <= comp_q;
        end
      endcase
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vrd_q  <= vmem[vaddr];
    crd_q  <= cmem[ptr_q[TAW-1:0]];
    nrd_q  <= nmem[ptr_q[TAW-1:0]];
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q <= cmd_i;
          for (int i = 0; i < 3; i++) begin
            res_n_q[i] <= '0;
            acc_q[i]   <= '0;
          end
          res_kind_q   <= (cmd_i.req == REQ_QUERY);
          res_status_q <= STAT_OK;
          if (cmd_i.req == REQ_VERTEX && vert_ok) begin
            vmem[vcount_q[VAW-1:0]] <= {cmd_i.pos_x, cmd_i.pos_y, cmd_i.pos_z};
          end
          if (cmd_i.req == REQ_QUERY) begin
            res_idx_q <= ItemW'(cmd_i.query_vertex);
            if (q_bad) begin
              res_status_q <= STAT_RANGE;
            end
          end else if (tri_full) begin
            res_idx_q    <= '0;
            res_status_q <= STAT_FULL;
          end else begin
            res_idx_q <= ItemW'(tcount_q);
            if (range_bad) begin
              res_status_q <= STAT_RANGE;
            end
          end
        end
      end
      S_FETCH: begin
        if (sub_q == 3'd1) pa_q <= vrd_q;
        if (sub_q == 3'd2) pb_q <= vrd_q;
        if (sub_q == 3'd3) begin
          for (int i = 0; i < 3; i++) begin
            e1_q[i] <= diff_c(pb_q, pa_q, i);
            e2_q[i] <= diff_c(vrd_q, pa_q, i);
          end
        end
      end
      S_CROSS: begin
        case (sub_q)
          3'd1: acc_q[0] <= acc_q[0] + AccW'(prod_q);
          3'd2: acc_q[0] <= acc_q[0] - AccW'(prod_q);
          3'd3: acc_q[1] <= acc_q[1] + AccW'(prod_q);
          3'd4: acc_q[1] <= acc_q[1] - AccW'(prod_q);
          3'd5: acc_q[2] <= acc_q[2] + AccW'(prod_q);
          3'd6: acc_q[2] <= acc_q[2] - AccW'(prod_q);
          default: acc_q[0] <= acc_q[0];
        endcase
      end
      S_WALK: begin
        if (issue_q && match) begin
          for (int i = 0; i < 3; i++) begin
            acc_q[i] <= acc_q[i] + AccW'($signed(nrd_q[(2-i)*NormW +: NormW]));
          end
        end
        if (walk_done && ucount_q == '0) begin
          res_status_q <= STAT_ZERO;
        end
      end
      S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= acc_q[i] < 0;
          mag_q[i] <= (acc_q[i] < 0) ? -acc_q[i] : acc_q[i];
        end
      end
      S_SHRINK: begin
        sum_q <= '0;
        if (big) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
        end
      end
      S_SQ: begin
        if (sub_q != 3'd0) begin
          sum_q <= sum_fin;
        end
        if (sub_q == 3'd3) begin
          rem_q  <= sum_fin;
          root_q <= '0;
          bit_q  <= SqW'(1) << (SqW - 2);
          if (sum_fin == '0) begin
            res_status_q <= STAT_ZERO;
          end
        end
      end
      S_SQRT: begin
        if ({1'b0, rem_q} >= sq_trial) begin
          rem_q  <= rem_q - sq_trial[SqW-1:0];
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_DIV_LOAD: begin
        num_q  <= (NumW'(mag_q[comp_q][MagLimit-1:0]) << NormFracBits) +
                  NumW'(root_q[LenW-1:0] >> 1);
        drem_q <= '0;
        quot_q <= '0;
      end
      S_DIV_RUN: begin
        num_q <= num_q << 1;
        if (div_sh >= {1'b0, root_q[LenW-1:0]}) begin
          drem_q <= div_sh - {1'b0, root_q[LenW-1:0]};
          quot_q <= {quot_q[NumW-2:0], 1'b1};
        end else begin
          drem_q <= div_sh;
          quot_q <= {quot_q[NumW-2:0], 1'b0};
        end
      end
      S_DIV_STORE: begin
        res_n_q[comp_q] <= neg_q[comp_q] ? -$signed(NormW'(capped)) : $signed(NormW'(capped));
      end
      S_EMIT: begin
        if (out_free) begin
          for (int i = 0; i < 3; i++) begin
            out_n_q[i] <= res_n_q[i];
          end
          out_kind_q   <= res_kind_q;
          out_idx_q    <= res_idx_q;
          out_count_q  <= CountW'(ucount_q);
          out_status_q <= res_status_q;
          if (store_tri_q) begin
            cmem[tcount_q[TAW-1:0]] <= {cmd_q.corner_a, cmd_q.corner_b, cmd_q.corner_c};
            nmem[tcount_q[TAW-1:0]] <= {res_n_q[0], res_n_q[1], res_n_q[2]};
          end
        end
      end
      default: begin
        sum_q <= sum_q;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign normal_x_o    = out_n_q[0];
  assign normal_y_o    = out_n_q[1];
  assign normal_z_o    = out_n_q[2];
  assign result_kind_o = out_kind_q;
  assign item_index_o  = out_idx_q;
  assign usage_count_o = out_count_q;
  assign status_o      = out_status_q;

endmodule

### src/mesh_vertex_normal_generator_unit.sv
// Top level of the mesh vertex normal generator.
// Items are queued two deep at the input and executed one at a time by the back end, whose
// result register lets the next item enter while a result waits. A vertex load or a clear
// is done in the idle state. A triangle load makes three vertex memory reads, six products
// on one shared multiplier, three squares, a 31-step square root and three 45-step
// divisions. A vertex query walks all stored triangles, reading one triangle per cycle from
// the corner and normal memories, before the same normalization. No clearing pass is
// needed after reset.
module mesh_vertex_normal_generator_unit #(
  parameter int MAX_VERTICES  = 1024,
  parameter int MAX_TRIANGLES = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         req_type_i,
  input  logic signed [mvng_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [mvng_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [mvng_pkg::CoordW-1:0] pos_z_i,
  input  logic [mvng_pkg::IdxW-1:0]          corner_a_i,
  input  logic [mvng_pkg::IdxW-1:0]          corner_b_i,
  input  logic [mvng_pkg::IdxW-1:0]          corner_c_i,
  input  logic [mvng_pkg::IdxW-1:0]          query_vertex_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mvng_pkg::NormW-1:0]  normal_x_o,
  output logic signed [mvng_pkg::NormW-1:0]  normal_y_o,
  output logic signed [mvng_pkg::NormW-1:0]  normal_z_o,
  output logic                               result_kind_o,
  output logic [mvng_pkg::ItemW-1:0]         item_index_o,
  output logic [mvng_pkg::CountW-1:0]        usage_count_o,
  output logic [1:0]                         status_o
);
  import mvng_pkg::*;

  cmd_t cmd;
  hs_t  cmd_hs;

  mvng_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .corner_a_i     (corner_a_i),
    .corner_b_i     (corner_b_i),
    .corner_c_i     (corner_c_i),
    .query_vertex_i (query_vertex_i),
    .cmd_o          (cmd),
    .cmd_valid_o    (cmd_hs.valid),
    .cmd_ready_i    (cmd_hs.ready)
  );

  mvng_back #(
    .MAX_VERTICES  (MAX_VERTICES),
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cmd_valid_i   (cmd_hs.valid),
    .cmd_ready_o   (cmd_hs.ready),
    .normal_x_o    (normal_x_o),
    .normal_y_o    (normal_y_o),
    .normal_z_o    (normal_z_o),
    .result_kind_o (result_kind_o),
    .item_index_o  (item_index_o),
    .usage_count_o (usage_count_o),
    .status_o      (status_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule
